// ===== rtl/abkf_pkg.sv =====
// abkf_pkg: shared widths, reset values and register indexes for the angle/bias filter
// no dependencies
package abkf_pkg;
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS = 16;
  localparam int REG_WIDTH = 32;
  localparam int IDX_WIDTH = 3;
  localparam int FIELD_WIDTH = 32;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_TIME_STEP = 3'd0,
    REG_ANGLE_NOISE = 3'd1,
    REG_BIAS_NOISE = 3'd2,
    REG_MEASURE_NOISE = 3'd3,
    REG_INITIAL_ANGLE = 3'd4
  } reg_index_t;

  localparam logic [30:0] TIME_STEP_RESET = 31'd655;
  localparam logic [30:0] ANGLE_NOISE_RESET = 31'd66;
  localparam logic [30:0] BIAS_NOISE_RESET = 31'd197;
  localparam logic [30:0] MEASURE_NOISE_RESET = 31'd1966;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1
  } op_t;

  typedef struct packed {
    logic start;
    op_t op;
  } unit_ctl_t;
endpackage

// ===== rtl/abkf_serial_unit.sv =====
// abkf_serial_unit: bit-serial saturating fixed-point multiply and divide
// depends on abkf_pkg
module abkf_serial_unit #(
  parameter int DATA_WIDTH = abkf_pkg::DATA_WIDTH,
  parameter int FRAC_BITS = abkf_pkg::FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  abkf_pkg::unit_ctl_t ctl,
  input  logic signed [DATA_WIDTH-1:0] a,
  input  logic signed [DATA_WIDTH-1:0] b,
  output logic done,
  output logic signed [DATA_WIDTH-1:0] result
);
  localparam int PW = 2 * DATA_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(PW + 1);
  localparam logic [DATA_WIDTH-1:0] VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic busy;
  abkf_pkg::op_t op;
  logic neg;
  logic [CW-1:0] count;
  logic [PW-1:0] acc;
  logic [PW-1:0] shf;
  logic [DATA_WIDTH:0] rem;
  logic [DATA_WIDTH-1:0] mb;
  logic [DATA_WIDTH-1:0] ua, ub;
  logic [DATA_WIDTH:0] rem_sh;
  logic [PW-1:0] mag;
  logic ovf;
  logic [DATA_WIDTH-1:0] lim;

  assign ua = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
  assign ub = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
  assign rem_sh = {rem[DATA_WIDTH-1:0], shf[PW-1]};

  always_comb begin
    lim = neg ? (VMAX + 1'b1) : VMAX;
    if (op == abkf_pkg::OP_MUL) begin
      mag = acc >> FRAC_BITS;
    end else begin
      mag = acc;
    end
    ovf = (mag > PW'(lim));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (count == '0);
      if (ctl.start && !busy) begin
        busy <= 1'b1;
        op <= ctl.op;
        neg <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
        acc <= '0;
        rem <= '0;
        mb <= ub;
        if (ctl.op == abkf_pkg::OP_MUL) begin
          shf <= PW'(ua);
          count <= CW'(DATA_WIDTH);
        end else begin
          shf <= PW'({ua, {FRAC_BITS{1'b0}}}) << (PW - DATA_WIDTH - FRAC_BITS);
          // zero divisor: finish at once with a zero quotient
          count <= (ub == '0) ? '0 : CW'(DATA_WIDTH + FRAC_BITS);
        end
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          if (op == abkf_pkg::OP_DIV && mb == '0) begin
            result <= '0;
          end else if (ovf) begin
            result <= neg ? ~VMAX : VMAX;
          end else begin
            result <= neg ? (~mag[DATA_WIDTH-1:0] + 1'b1) : mag[DATA_WIDTH-1:0];
          end
        end else begin
          count <= count - 1'b1;
          if (op == abkf_pkg::OP_MUL) begin
            if (mb[0]) begin
              acc <= acc + shf;
            end
            shf <= shf << 1;
            mb <= mb >> 1;
          end else begin
            shf <= shf << 1;
            if (rem_sh >= {1'b0, mb}) begin
              rem <= rem_sh - {1'b0, mb};
              acc <= {acc[PW-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              acc <= {acc[PW-2:0], 1'b0};
            end
          end
        end
      end
    end
  end
endmodule

// ===== rtl/angle_bias_kalman_filter_unit.sv =====
// angle_bias_kalman_filter_unit: two-state angle/gyro-bias kalman filter, top level
// depends on abkf_pkg and abkf_serial_unit
//
// usage: write time_step, noises and initial_angle on the cfg port while idle.
// each input beat carries accel_angle and gyro_rate; one output beat with
// angle_estimate and bias_estimate follows for every input beat.
// all math is signed fixed point with saturation. products and quotients run
// one at a time through a single bit-serial multiply/divide unit (a zero
// divisor finishes early).
// one sample uses 10 multiplies and 2 divides (plus 2 more multiplies on
// the first sample after reset); the output beat is ready once the last
// of these steps is done.
// one sample is worked at a time; in_ready is high only while idle, so a new
// input is not taken until the current one has been worked and sent.
// the result is held in an output register; a stalled receiver holds the
// block until the beat is taken, then the next input is accepted.
// reset restores register defaults and clears state; the first sample after
// reset loads initial_angle, zero bias and P00 = dt*dt*q_angle.
module angle_bias_kalman_filter_unit #(
  parameter int DATA_WIDTH = abkf_pkg::DATA_WIDTH,
  parameter int FRAC_BITS = abkf_pkg::FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [abkf_pkg::IDX_WIDTH-1:0] cfg_index,
  input  logic [abkf_pkg::REG_WIDTH-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [abkf_pkg::FIELD_WIDTH-1:0] accel_angle,
  input  logic signed [abkf_pkg::FIELD_WIDTH-1:0] gyro_rate,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [abkf_pkg::FIELD_WIDTH-1:0] angle_estimate,
  output logic signed [abkf_pkg::FIELD_WIDTH-1:0] bias_estimate
);
  localparam int W = DATA_WIDTH;
  localparam int FW = abkf_pkg::FIELD_WIDTH;
  localparam int XW = (W > FW) ? W : FW;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SRC_DT, SRC_K0, SRC_K1, SRC_T
  } src_t;

  typedef struct packed {
    abkf_pkg::op_t op;
    src_t sa;
    logic [3:0] bsel;
  } step_t;

  // b operand selects
  localparam logic [3:0] B_DT = 4'd0, B_QA = 4'd1, B_BIAS = 4'd2, B_GYRO = 4'd3,
    B_P11 = 4'd4, B_SUM = 4'd5, B_Y = 4'd6, B_P00 = 4'd7, B_P01 = 4'd8,
    B_S = 4'd9, B_P10 = 4'd10, B_T = 4'd11;

  logic [30:0] time_step, angle_noise, bias_noise, measure_noise;
  logic [abkf_pkg::REG_WIDTH-1:0] initial_angle;
  logic primed;
  state_t state;
  logic [4:0] step;
  logic signed [W-1:0] angle, bias, c00, c01, c10, c11;
  logic signed [W-1:0] accel, gyro, ap, t, k0, k1, y, s, sum;
  logic signed [W-1:0] dt, qa, qb, rr;
  logic signed [W-1:0] op_a, op_b, res;
  logic u_done;
  abkf_pkg::unit_ctl_t ctl;
  step_t cur;

  function automatic logic signed [W-1:0] sat_u(input logic [30:0] v);
    if (W > 31 || v <= 31'(VMAX)) begin
      return W'(v);
    end
    return VMAX;
  endfunction

  function automatic logic signed [W-1:0] sat_s(input logic signed [FW-1:0] v);
    logic signed [XW:0] e;
    e = (XW+1)'(v);
    if (e > XW'(VMAX)) begin
      return VMAX;
    end
    if (e < (XW+1)'(VMIN)) begin
      return VMIN;
    end
    return W'(v);
  endfunction

  function automatic logic signed [FW-1:0] to_out(input logic signed [W-1:0] v);
    logic signed [XW:0] e;
    logic signed [XW:0] hi;
    logic signed [XW:0] lo;
    e = (XW+1)'(v);
    hi = (XW+1)'($signed({1'b0, {(FW-1){1'b1}}}));
    lo = (XW+1)'($signed({1'b1, {(FW-1){1'b0}}}));
    if (e > hi) begin
      return hi[FW-1:0];
    end
    if (e < lo) begin
      return lo[FW-1:0];
    end
    return FW'(v);
  endfunction

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] x,
                                              input logic signed [W-1:0] z);
    logic signed [W:0] e;
    e = (W+1)'(x) + (W+1)'(z);
    if (e[W] != e[W-1]) begin
      return e[W] ? VMIN : VMAX;
    end
    return e[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] x,
                                              input logic signed [W-1:0] z);
    logic signed [W:0] e;
    e = (W+1)'(x) - (W+1)'(z);
    if (e[W] != e[W-1]) begin
      return e[W] ? VMIN : VMAX;
    end
    return e[W-1:0];
  endfunction

  assign dt = sat_u(time_step);
  assign qa = sat_u(angle_noise);
  assign qb = sat_u(bias_noise);
  assign rr = sat_u(measure_noise);

  // step list; steps 0..1 only on the first sample
  always_comb begin
    cur = '{abkf_pkg::OP_MUL, SRC_DT, B_DT};
    case (step)
      5'd0: cur = '{abkf_pkg::OP_MUL, SRC_DT, B_DT};
      5'd1: cur = '{abkf_pkg::OP_MUL, SRC_T, B_QA};
      5'd2: cur = '{abkf_pkg::OP_MUL, SRC_DT, B_BIAS};
      5'd3: cur = '{abkf_pkg::OP_MUL, SRC_DT, B_GYRO};
      5'd4: cur = '{abkf_pkg::OP_MUL, SRC_DT, B_P11};
      5'd5: cur = '{abkf_pkg::OP_MUL, SRC_DT, B_SUM};
      5'd6: cur = '{abkf_pkg::OP_DIV, SRC_T, B_S};
      5'd7: cur = '{abkf_pkg::OP_DIV, SRC_T, B_S};
      5'd8: cur = '{abkf_pkg::OP_MUL, SRC_K0, B_Y};
      5'd9: cur = '{abkf_pkg::OP_MUL, SRC_K1, B_Y};
      5'd10: cur = '{abkf_pkg::OP_MUL, SRC_K0, B_P00};
      5'd11: cur = '{abkf_pkg::OP_MUL, SRC_K1, B_P01};
      5'd12: cur = '{abkf_pkg::OP_MUL, SRC_K1, B_P00};
      5'd13: cur = '{abkf_pkg::OP_MUL, SRC_K0, B_P01};
      default: cur = '{abkf_pkg::OP_MUL, SRC_DT, B_DT};
    endcase
  end

  always_comb begin
    case (cur.sa)
      SRC_DT: op_a = dt;
      SRC_K0: op_a = k0;
      SRC_K1: op_a = k1;
      default: op_a = t;
    endcase
    // divide numerators: step 6 uses c00 (p00), step 7 uses c10 (p10)
    if (step == 5'd6) begin
      op_a = c00;
    end else if (step == 5'd7) begin
      op_a = c10;
    end
    case (cur.bsel)
      B_DT: op_b = dt;
      B_QA: op_b = qa;
      B_BIAS: op_b = bias;
      B_GYRO: op_b = gyro;
      B_P11: op_b = c11;
      B_SUM: op_b = sum;
      B_Y: op_b = y;
      B_P00: op_b = c00;
      B_P01: op_b = c01;
      B_S: op_b = s;
      default: op_b = t;
    endcase
  end

  abkf_serial_unit #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_unit (
    .clk(clk), .rst(rst), .ctl(ctl), .a(op_a), .b(op_b), .done(u_done), .result(res)
  );

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= abkf_pkg::TIME_STEP_RESET;
      angle_noise <= abkf_pkg::ANGLE_NOISE_RESET;
      bias_noise <= abkf_pkg::BIAS_NOISE_RESET;
      measure_noise <= abkf_pkg::MEASURE_NOISE_RESET;
      initial_angle <= '0;
      primed <= 1'b0;
      state <= ST_IDLE;
      out_valid <= 1'b0;
      ctl <= '0;
      step <= '0;
      angle <= '0;
      bias <= '0;
      c00 <= '0;
      c01 <= '0;
      c10 <= '0;
      c11 <= '0;
    end else begin
      ctl.start <= (state == ST_ISSUE);
      if (cfg_write) begin
        case (cfg_index)
          abkf_pkg::REG_TIME_STEP: time_step <= cfg_data[30:0];
          abkf_pkg::REG_ANGLE_NOISE: angle_noise <= cfg_data[30:0];
          abkf_pkg::REG_BIAS_NOISE: bias_noise <= cfg_data[30:0];
          abkf_pkg::REG_MEASURE_NOISE: measure_noise <= cfg_data[30:0];
          abkf_pkg::REG_INITIAL_ANGLE: initial_angle <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            accel <= sat_s(accel_angle);
            gyro <= sat_s(gyro_rate);
            if (!primed) begin
              primed <= 1'b1;
              angle <= sat_s(FW'(initial_angle));
              bias <= '0;
              c01 <= '0;
              c10 <= '0;
              c11 <= '0;
              step <= 5'd0;
            end else begin
              step <= 5'd2;
            end
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          ctl.op <= cur.op;
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (u_done) begin
            state <= (step == 5'd13) ? ST_OUT : ST_ISSUE;
            step <= step + 1'b1;
            case (step)
              5'd0: t <= res;
              5'd1: c00 <= res;
              5'd2: ap <= ssub(angle, res);
              5'd3: ap <= sadd(ap, res);
              5'd4: begin
                t <= res;
                sum <= ssub(sadd(c01, c10), res);
                c01 <= ssub(c01, res);
                c10 <= ssub(c10, res);
                c11 <= sadd(c11, qb);
              end
              5'd5: begin
                c00 <= sadd(ssub(c00, res), qa);
                s <= sadd(sadd(ssub(c00, res), qa), rr);
                y <= ssub(accel, ap);
              end
              5'd6: k0 <= res;
              5'd7: k1 <= res;
              5'd8: angle <= sadd(ap, res);
              5'd9: bias <= sadd(bias, res);
              5'd10: t <= res;
              5'd11: c11 <= ssub(c11, res);
              5'd12: c10 <= ssub(c10, res);
              5'd13: begin
                c01 <= ssub(c01, res);
                c00 <= ssub(c00, t);
                angle_estimate <= to_out(angle);
                bias_estimate <= to_out(bias);
                out_valid <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for angle_bias_kalman_filter_unit, driven through valid/ready beats
// depends on abkf_pkg and the filter rtl; predicts each output beat with a saturating Q16.16 model
module tb;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [abkf_pkg::IDX_WIDTH-1:0] cfg_index = '0;
  logic [abkf_pkg::REG_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] accel_angle = '0;
  logic signed [31:0] gyro_rate = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] angle_estimate;
  logic signed [31:0] bias_estimate;

  angle_bias_kalman_filter_unit dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .accel_angle(accel_angle), .gyro_rate(gyro_rate), .out_valid(out_valid),
    .out_ready(out_ready), .angle_estimate(angle_estimate),
    .bias_estimate(bias_estimate)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // filter state of the predictor
  longint m_dt, m_qa, m_qb, m_r, m_init;
  longint m_angle, m_bias;
  longint m_p[4];
  bit m_primed;

  logic [31:0] exp_angle_q[$];
  logic [31:0] exp_bias_q[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit no_idle = 1'b0;

  function automatic longint sat(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic signed [127:0] p;
    logic signed [127:0] s;
    p = 128'(signed'(a)) * 128'(signed'(b));
    if (p < 0) s = -((-p) >>> abkf_pkg::FRAC_BITS);
    else s = p >>> abkf_pkg::FRAC_BITS;
    if (s > VMAX) return VMAX;
    if (s < VMIN) return VMIN;
    return longint'(s);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    logic signed [127:0] nn;
    logic signed [127:0] q;
    if (d == 0) return 0;
    nn = 128'(signed'(n)) <<< abkf_pkg::FRAC_BITS;
    q = nn / 128'(signed'(d));
    if (q > VMAX) return VMAX;
    if (q < VMIN) return VMIN;
    return longint'(q);
  endfunction

  function automatic void reset_filter();
    m_dt = 655; m_qa = 66; m_qb = 197; m_r = 1966; m_init = 0;
    m_angle = 0; m_bias = 0;
    for (int i = 0; i < 4; i++) m_p[i] = 0;
    m_primed = 1'b0;
  endfunction

  function automatic void write_shadow(abkf_pkg::reg_index_t idx, logic [31:0] v);
    case (idx)
      abkf_pkg::REG_TIME_STEP: m_dt = v[30:0];
      abkf_pkg::REG_ANGLE_NOISE: m_qa = v[30:0];
      abkf_pkg::REG_BIAS_NOISE: m_qb = v[30:0];
      abkf_pkg::REG_MEASURE_NOISE: m_r = v[30:0];
      abkf_pkg::REG_INITIAL_ANGLE: m_init = longint'(signed'(v));
      default: ;
    endcase
  endfunction

  function automatic void filter_step(logic signed [31:0] acc, logic signed [31:0] gyr);
    longint ap, p00, p01, p10, p11, y, s, k0, k1;
    if (!m_primed) begin
      m_angle = m_init;
      m_bias = 0;
      m_p[0] = qmul(qmul(m_dt, m_dt), m_qa);
      m_p[1] = 0; m_p[2] = 0; m_p[3] = 0;
      m_primed = 1'b1;
    end
    ap = sat(sat(m_angle - qmul(m_dt, m_bias)) + qmul(m_dt, gyr));
    p00 = sat(sat(m_p[0] - qmul(m_dt, sat(sat(m_p[1] + m_p[2]) - qmul(m_dt, m_p[3]))))
          + m_qa);
    p01 = sat(m_p[1] - qmul(m_dt, m_p[3]));
    p10 = sat(m_p[2] - qmul(m_dt, m_p[3]));
    p11 = sat(m_p[3] + m_qb);
    y = sat(longint'(acc) - ap);
    s = sat(p00 + m_r);
    k0 = qdiv(p00, s);
    k1 = qdiv(p10, s);
    m_angle = sat(ap + qmul(k0, y));
    m_bias = sat(m_bias + qmul(k1, y));
    m_p[0] = sat(p00 - qmul(k0, p00));
    m_p[1] = sat(p01 - qmul(k0, p01));
    m_p[2] = sat(p10 - qmul(k1, p00));
    m_p[3] = sat(p11 - qmul(k1, p01));
    exp_angle_q.push_back(m_angle[31:0]);
    exp_bias_q.push_back(m_bias[31:0]);
  endfunction

  task automatic cfg_put(abkf_pkg::reg_index_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    write_shadow(idx, v);
  endtask

  // valid stays high after the beat is taken until the next beat or drain
  task automatic send_beat(logic [31:0] acc, logic [31:0] gyr);
    while (!no_idle && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    accel_angle <= acc;
    gyro_rate <= gyr;
    filter_step(acc, gyr);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_angle_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(131072) - 65536;
      3: return ($urandom_range(1) ? 32'sd1 : -32'sd1) * $urandom_range(655360);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_config();
    cfg_put(abkf_pkg::REG_TIME_STEP,
            $urandom_range(1) ? $urandom_range(1, 6554) : $urandom);
    cfg_put(abkf_pkg::REG_ANGLE_NOISE,
            $urandom_range(3) == 0 ? $urandom : $urandom_range(3000));
    cfg_put(abkf_pkg::REG_BIAS_NOISE,
            $urandom_range(3) == 0 ? $urandom : $urandom_range(3000));
    cfg_put(abkf_pkg::REG_MEASURE_NOISE,
            $urandom_range(3) == 0 ? $urandom : $urandom_range(1, 70000));
    cfg_put(abkf_pkg::REG_INITIAL_ANGLE, rand_field());
  endtask

  typedef struct {
    logic [31:0] acc;
    logic [31:0] gyr;
  } beat_row_t;

  beat_row_t stim_rows[] = '{
    '{32'h00000000, 32'h00000000}, '{32'h7fffffff, 32'h00000000},
    '{32'h80000000, 32'h00000000}, '{32'h00000000, 32'h7fffffff},
    '{32'h00000000, 32'h80000000}, '{32'h7fffffff, 32'h7fffffff},
    '{32'h80000000, 32'h80000000}, '{32'h00010000, 32'hffff0000},
    '{32'hffffffff, 32'h00000001}, '{32'h00000001, 32'hffffffff},
    '{32'h55555555, 32'haaaaaaaa}, '{32'haaaaaaaa, 32'h55555555}
  };

  initial begin
    reset_filter();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    // first output after reset: zero inputs at defaults stay at zero
    send_beat(32'h0, 32'h0);
    drain();
    if (angle_estimate !== 32'sd0 || bias_estimate !== 32'sd0) begin
      $display("%0t first beat: expected 0/0, got %0d/%0d", $time, angle_estimate,
               bias_estimate);
      errors = errors + 1;
    end
    foreach (stim_rows[i]) send_beat(stim_rows[i].acc, stim_rows[i].gyr);
    drain();
    // extremes of the registers
    cfg_put(abkf_pkg::REG_TIME_STEP, 32'h7fffffff);
    cfg_put(abkf_pkg::REG_ANGLE_NOISE, 32'h7fffffff);
    cfg_put(abkf_pkg::REG_BIAS_NOISE, 32'h7fffffff);
    cfg_put(abkf_pkg::REG_MEASURE_NOISE, 32'h7fffffff);
    cfg_put(abkf_pkg::REG_INITIAL_ANGLE, 32'h80000000);
    for (int i = 0; i < 4; i++) send_beat(stim_rows[i].acc, stim_rows[i].gyr);
    drain();
    cfg_put(abkf_pkg::REG_TIME_STEP, 32'd1);
    cfg_put(abkf_pkg::REG_ANGLE_NOISE, 32'd0);
    cfg_put(abkf_pkg::REG_BIAS_NOISE, 32'd0);
    cfg_put(abkf_pkg::REG_MEASURE_NOISE, 32'd1);
    cfg_put(abkf_pkg::REG_INITIAL_ANGLE, 32'h7fffffff);
    for (int i = 4; i < 8; i++) send_beat(stim_rows[i].acc, stim_rows[i].gyr);
    drain();
    // out-of-list index is ignored
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= 3'd7;
    cfg_data <= $urandom;
    @(negedge clk);
    cfg_write <= 1'b0;
    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      if (ph == 3) no_idle = 1'b1;
      if (ph == 4) no_idle = 1'b0;
      if (ph == 6) hold_off = 1'b1;
      for (int i = 0; i < 50; i++) send_beat(rand_field(), rand_field());
      drain();
    end
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
      repeat (3000) @(negedge clk);
      hold_off = 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (exp_angle_q.size() == 0) begin
        $display("%0t unexpected beat: got %0d/%0d", $time, angle_estimate, bias_estimate);
        errors = errors + 1;
      end else begin
        if (angle_estimate !== exp_angle_q[0]) begin
          $display("%0t angle_estimate: expected %0d, got %0d", $time,
                   $signed(exp_angle_q[0]), angle_estimate);
          errors = errors + 1;
        end
        if (bias_estimate !== exp_bias_q[0]) begin
          $display("%0t bias_estimate: expected %0d, got %0d", $time,
                   $signed(exp_bias_q[0]), bias_estimate);
          errors = errors + 1;
        end
        void'(exp_angle_q.pop_front());
        void'(exp_bias_q.pop_front());
      end
    end
  end
endmodule

// ===== files.f =====
rtl/abkf_pkg.sv
rtl/abkf_serial_unit.sv
rtl/angle_bias_kalman_filter_unit.sv
bench/tb.sv
